>>> sv/cdtss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdtss_pkg;

    localparam int VAL_W      = 27;
    localparam int COUNT_W    = VAL_W + 1;
    localparam int NUM_DIGITS = 8;
    localparam int OUT_DIGITS = 8;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = $clog2(VAL_W + 1);
    localparam int SEG_W      = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 1'd1;

    typedef struct packed {
        logic run_on;
        logic reset_switch;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0] seg_digit0;
        logic [SEG_W-1:0] seg_digit1;
        logic [SEG_W-1:0] seg_digit2;
        logic [SEG_W-1:0] seg_digit3;
        logic [SEG_W-1:0] seg_digit4;
        logic [SEG_W-1:0] seg_digit5;
        logic [SEG_W-1:0] seg_digit6;
        logic [SEG_W-1:0] seg_digit7;
        logic             display_valid;
        logic             config_error;
    } t_out_item;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'd252;
            4'd1:    seg = 8'd96;
            4'd2:    seg = 8'd218;
            4'd3:    seg = 8'd242;
            4'd4:    seg = 8'd102;
            4'd5:    seg = 8'd182;
            4'd6:    seg = 8'd190;
            4'd7:    seg = 8'd224;
            4'd8:    seg = 8'd254;
            4'd9:    seg = 8'd246;
            default: seg = 8'd0;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> sv/cdtss_bcd_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module cdtss_bcd_conv (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [cdtss_pkg::VAL_W-1:0] i_value,
    output logic                             o_done,
    output logic [cdtss_pkg::BCD_W-1:0]      o_bcd
);

    logic [cdtss_pkg::VAL_W-1:0] r_bin;
    logic [cdtss_pkg::BCD_W-1:0] r_bcd;
    logic [cdtss_pkg::CNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [cdtss_pkg::BCD_W-1:0] n_adj;

    // Each digit of five or more gets three added before the shift.
    always_comb begin
        n_adj = r_bcd;
        for (int d = 0; d < cdtss_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= cdtss_pkg::CNT_W'(cdtss_pkg::VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - cdtss_pkg::CNT_W'(1);
                if (r_cnt == cdtss_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[cdtss_pkg::VAL_W-2:0], 1'b0};
            r_bcd <= {n_adj[cdtss_pkg::BCD_W-2:0], r_bin[cdtss_pkg::VAL_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

>>> sv/countdown_timer_seven_segment.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in_item  (run and reset switches)
// out      output     o_out_valid / i_out_ready  o_out_item (eight digits, flags)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A tick runs from its transfer through 27 shift steps of the shift-and-add-three
// unit; the controller then sees the done flag and loads the output register. The
// next tick can transfer only once that result is loaded, back in the idle state.
// Reset is synchronous and active low and clears the count, the shown value and
// the armed flag. A waiting result does not block the next tick from starting;
// only loading a new result waits for the output register to be free.
// Configuration writes are always accepted.

module countdown_timer_seven_segment (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire cdtss_pkg::t_in_item             i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output cdtss_pkg::t_out_item                 o_out_item,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cdtss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cdtss_pkg::VAL_W-1:0]     i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                      r_state;
    logic [cdtss_pkg::VAL_W-1:0]     r_start;
    logic [cdtss_pkg::VAL_W-1:0]     r_stop;
    logic [cdtss_pkg::COUNT_W-1:0]   r_count;
    logic [cdtss_pkg::VAL_W-1:0]     r_shown;
    logic                            r_armed;
    logic                            r_out_valid;
    cdtss_pkg::t_out_item            r_out;

    logic [cdtss_pkg::COUNT_W-1:0]   n_count;
    logic [cdtss_pkg::VAL_W-1:0]     n_shown;
    logic                            n_armed;
    logic                            w_in_xfer;
    logic                            w_load;
    logic                            w_conv_done;
    logic [cdtss_pkg::BCD_W-1:0]     w_bcd;
    logic [cdtss_pkg::BCD_DIGITS-1:0] w_nz;
    logic [cdtss_pkg::SEG_W-1:0]     w_seg [cdtss_pkg::OUT_DIGITS];
    cdtss_pkg::t_out_item            w_out;

    function automatic logic [cdtss_pkg::VAL_W-1:0] shown_of(
        input logic [cdtss_pkg::COUNT_W-1:0] count
    );
        return count[cdtss_pkg::COUNT_W-1] ? '0 : count[cdtss_pkg::VAL_W-1:0];
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_stop  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cdtss_pkg::CFG_START: r_start <= i_cfg_data;
                cdtss_pkg::CFG_STOP:  r_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_armed = r_armed;
        n_count = r_count;
        n_shown = r_shown;
        if (!r_armed) begin
            if (!i_in_item.run_on && !i_in_item.reset_switch) begin
                n_armed = 1'b1;
                n_count = {1'b0, r_start};
                n_shown = r_start;
            end
        end else if (i_in_item.reset_switch) begin
            n_count = {1'b0, r_start};
            n_shown = r_start;
        end else if (!i_in_item.run_on) begin
            n_shown = shown_of(r_count);
        end else if ($signed(r_count) >= $signed({1'b0, r_stop})) begin
            n_shown = shown_of(r_count);
            n_count = r_count - cdtss_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_armed <= 1'b0;
            r_count <= '0;
            r_shown <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_armed <= n_armed;
                        r_count <= n_count;
                        r_shown <= n_shown;
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (w_conv_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    cdtss_bcd_conv u_bcd_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer),
        .i_value (n_shown),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    // While armed, a digit is lit when it or any higher digit is nonzero; the ones digit always is.
    always_comb begin
        w_nz[cdtss_pkg::BCD_DIGITS-1] = |w_bcd[cdtss_pkg::BCD_W-1 -: 4];
        for (int d = cdtss_pkg::BCD_DIGITS - 2; d >= 0; d--) begin
            w_nz[d] = w_nz[d+1] || (|w_bcd[d*4 +: 4]);
        end
        for (int k = 0; k < cdtss_pkg::OUT_DIGITS; k++) begin
            if (r_armed && (k < cdtss_pkg::NUM_DIGITS) && ((k == 0) || w_nz[k])) begin
                w_seg[k] = cdtss_pkg::seg_of(w_bcd[k*4 +: 4]);
            end else begin
                w_seg[k] = '0;
            end
        end
    end

    always_comb begin
        w_out.seg_digit0    = w_seg[0];
        w_out.seg_digit1    = w_seg[1];
        w_out.seg_digit2    = w_seg[2];
        w_out.seg_digit3    = w_seg[3];
        w_out.seg_digit4    = w_seg[4];
        w_out.seg_digit5    = w_seg[5];
        w_out.seg_digit6    = w_seg[6];
        w_out.seg_digit7    = w_seg[7];
        w_out.display_valid = r_armed;
        w_out.config_error  = (r_start < r_stop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[cdtss_pkg::COUNT_W-1] |-> (&r_count))
        else $error("count fell below minus one");

    a_unarmed_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_shown == '0) && (r_count == '0))
        else $error("count or shown value changed before arming");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |-> (r_state == ST_CONV))
        else $error("conversion finished outside the conversion state");

    a_xfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_CONV) && !w_conv_done)
        else $error("input transfer did not start a conversion");

    a_valid_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.display_valid) |-> r_armed)
        else $error("display shown valid while not armed");

endmodule

`default_nettype wire
